/* rtl/core/lipm_fp_pkg.sv */
// ---------------------------------------------------------------------------
// lipm_fp_pkg
// Shared types, constants and the micro-program of the footstep planner.
// ---------------------------------------------------------------------------
package lipm_fp_pkg;

    // fixed-point constants, Q16.16
    localparam logic signed [31:0] Q_ONE        = 32'sd65536;
    localparam logic signed [31:0] Q_HALF       = 32'sd32768;
    localparam logic signed [31:0] Q_NHALF      = -32'sd32768;
    localparam logic signed [31:0] FIRST_FOOT_Y = -32'sd6554;
    localparam logic signed [31:0] S32_MAX      = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN      = 32'sh80000000;

    // step limit and step counter width
    localparam int STEP_W    = 7;
    localparam int MAX_STEPS = 64;

    // divider: 32-bit dividend scaled by 2^16
    localparam int DIV_BITS = 48;
    localparam int DIV_CW   = $clog2(DIV_BITS);

    // configuration register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_COSH    = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_SINH    = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_TC      = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_WPOS    = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_WVEL    = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_START_X = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_START_Y = 3'd6;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_SAT   = 2'd1;
    localparam logic [1:0] STAT_LIMIT = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_WB,
        S_DONE
    } t_state;

    // operations of the shared unit
    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_PM,     // subtract on even steps, add on odd steps
        OP_MUL,
        OP_DIV
    } t_op;

    // operand codes: bit 6 clear selects a scratch slot, set a special source
    localparam int SRC_W = 7;
    localparam int SLOT_W = 6;
    localparam logic [SRC_W-1:0] R_PSX = 7'd0;
    localparam logic [SRC_W-1:0] R_PSY = 7'd1;
    localparam logic [SRC_W-1:0] R_FPX = 7'd2;
    localparam logic [SRC_W-1:0] R_FPY = 7'd3;
    localparam logic [SRC_W-1:0] R_BPX = 7'd4;
    localparam logic [SRC_W-1:0] R_BPY = 7'd5;
    localparam logic [SRC_W-1:0] R_BVX = 7'd6;
    localparam logic [SRC_W-1:0] R_BVY = 7'd7;
    localparam logic [SRC_W-1:0] R_LFX = 7'd8;
    localparam logic [SRC_W-1:0] R_LFY = 7'd9;
    localparam logic [SRC_W-1:0] R_TCS = 7'd10;
    localparam logic [SRC_W-1:0] R_SOT = 7'd11;
    localparam logic [SRC_W-1:0] R_CP1 = 7'd12;
    localparam logic [SRC_W-1:0] R_CM1 = 7'd13;
    localparam logic [SRC_W-1:0] R_OMC = 7'd14;
    localparam logic [SRC_W-1:0] R_HX  = 7'd15;
    localparam logic [SRC_W-1:0] R_HY  = 7'd16;
    localparam logic [SRC_W-1:0] R_LX  = 7'd17;
    localparam logic [SRC_W-1:0] R_LY  = 7'd18;
    localparam logic [SRC_W-1:0] R_TX  = 7'd19;
    localparam logic [SRC_W-1:0] R_TY  = 7'd20;
    localparam logic [SRC_W-1:0] R_TVX = 7'd21;
    localparam logic [SRC_W-1:0] R_TVY = 7'd22;
    localparam logic [SRC_W-1:0] R_PX  = 7'd23;
    localparam logic [SRC_W-1:0] R_PY  = 7'd24;
    localparam logic [SRC_W-1:0] R_VX  = 7'd25;
    localparam logic [SRC_W-1:0] R_VY  = 7'd26;
    localparam logic [SRC_W-1:0] R_D   = 7'd27;
    localparam logic [SRC_W-1:0] R_KA  = 7'd28;
    localparam logic [SRC_W-1:0] R_KB  = 7'd29;
    localparam logic [SRC_W-1:0] R_T1  = 7'd30;
    localparam logic [SRC_W-1:0] R_T2  = 7'd31;
    localparam logic [SRC_W-1:0] R_U   = 7'd32;
    localparam logic [SRC_W-1:0] R_W   = 7'd33;

    localparam logic [SRC_W-1:0] K_ZERO  = 7'd64;
    localparam logic [SRC_W-1:0] K_ONE   = 7'd65;
    localparam logic [SRC_W-1:0] K_HALF  = 7'd66;
    localparam logic [SRC_W-1:0] K_NHALF = 7'd67;
    localparam logic [SRC_W-1:0] K_SGNH  = 7'd68;
    localparam logic [SRC_W-1:0] K_FOOTY = 7'd69;
    localparam logic [SRC_W-1:0] K_C     = 7'd70;
    localparam logic [SRC_W-1:0] K_S     = 7'd71;
    localparam logic [SRC_W-1:0] K_TC    = 7'd72;
    localparam logic [SRC_W-1:0] K_A     = 7'd73;
    localparam logic [SRC_W-1:0] K_B     = 7'd74;
    localparam logic [SRC_W-1:0] K_SPX   = 7'd75;
    localparam logic [SRC_W-1:0] K_SPY   = 7'd76;
    localparam logic [SRC_W-1:0] K_SX    = 7'd77;
    localparam logic [SRC_W-1:0] K_SY    = 7'd78;

    // micro-program layout
    localparam int PC_W = 7;
    localparam logic [PC_W-1:0] STEP0_PC = 7'd5;
    localparam logic [PC_W-1:0] STEPN_PC = 7'd19;

    typedef struct packed {
        t_op              op;
        logic [SRC_W-1:0] dst;
        logic [SRC_W-1:0] a;
        logic [SRC_W-1:0] b;
        logic             branch; // branch to the step 0 or step n routine
        logic             last;
    } t_instr;

    // saturated value with overflow flag
    typedef struct packed {
        logic              ovf;
        logic signed [31:0] val;
    } t_satv;

    function automatic t_satv sat64(input logic signed [63:0] v);
        t_satv r;
        if (v > 64'(S32_MAX)) begin
            r = '{1'b1, S32_MAX};
        end else if (v < 64'(S32_MIN)) begin
            r = '{1'b1, S32_MIN};
        end else begin
            r = '{1'b0, v[31:0]};
        end
        return r;
    endfunction

    function automatic t_instr mk(input t_op op, input logic [SRC_W-1:0] d,
                                  input logic [SRC_W-1:0] a, input logic [SRC_W-1:0] b);
        t_instr r;
        r = '{op, d, a, b, 1'b0, 1'b0};
        return r;
    endfunction

    // the micro-program
    function automatic t_instr prog_rom(input logic [PC_W-1:0] pc);
        t_instr r;
        case (pc)
            // common terms
            7'd0:  r = mk(OP_MUL, R_TCS, K_TC, K_S);
            7'd1:  r = mk(OP_DIV, R_SOT, K_S, K_TC);
            7'd2:  r = mk(OP_ADD, R_CP1, K_C, K_ONE);
            7'd3:  r = mk(OP_SUB, R_CM1, K_C, K_ONE);
            7'd4:  begin
                r = mk(OP_SUB, R_OMC, K_ONE, K_C);
                r.branch = 1'b1;
            end
            // first step of a plan
            7'd5:  r = mk(OP_MUL, R_HX, K_SX, K_HALF);
            7'd6:  r = mk(OP_MUL, R_HY, K_SY, K_NHALF);
            7'd7:  r = mk(OP_MUL, R_U, R_CP1, R_HX);
            7'd8:  r = mk(OP_DIV, R_BVX, R_U, R_TCS);
            7'd9:  r = mk(OP_MUL, R_U, R_CM1, R_HY);
            7'd10: r = mk(OP_DIV, R_BVY, R_U, R_TCS);
            7'd11: r = mk(OP_ADD, R_LFX, K_ZERO, K_ZERO);
            7'd12: r = mk(OP_ADD, R_LFY, K_FOOTY, K_ZERO);
            7'd13: r = mk(OP_ADD, R_FPX, K_ZERO, K_ZERO);
            7'd14: r = mk(OP_ADD, R_FPY, K_FOOTY, K_ZERO);
            7'd15: r = mk(OP_ADD, R_BPX, K_SPX, K_ZERO);
            7'd16: r = mk(OP_ADD, R_BPY, K_SPY, K_ZERO);
            7'd17: r = mk(OP_ADD, R_PSX, K_SX, K_ZERO);
            7'd18: begin
                r = mk(OP_ADD, R_PSY, K_SY, K_ZERO);
                r.last = 1'b1;
            end
            // later steps: footprint and targets
            7'd19: r = mk(OP_ADD, R_LX, R_FPX, R_PSX);
            7'd20: r = mk(OP_PM,  R_U, K_ZERO, R_PSY);
            7'd21: r = mk(OP_ADD, R_LY, R_FPY, R_U);
            7'd22: r = mk(OP_MUL, R_HX, K_SX, K_HALF);
            7'd23: r = mk(OP_MUL, R_HY, K_SY, K_SGNH);
            7'd24: r = mk(OP_ADD, R_TX, R_LX, R_HX);
            7'd25: r = mk(OP_ADD, R_TY, R_LY, R_HY);
            7'd26: r = mk(OP_MUL, R_U, R_CP1, R_HX);
            7'd27: r = mk(OP_DIV, R_TVX, R_U, R_TCS);
            7'd28: r = mk(OP_MUL, R_U, R_CM1, R_HY);
            7'd29: r = mk(OP_DIV, R_TVY, R_U, R_TCS);
            // start position
            7'd30: r = mk(OP_MUL, R_U, K_C, R_BPX);
            7'd31: r = mk(OP_MUL, R_W, R_TCS, R_BVX);
            7'd32: r = mk(OP_ADD, R_U, R_U, R_W);
            7'd33: r = mk(OP_MUL, R_W, R_OMC, R_LFX);
            7'd34: r = mk(OP_ADD, R_PX, R_U, R_W);
            7'd35: r = mk(OP_MUL, R_U, K_C, R_BPY);
            7'd36: r = mk(OP_MUL, R_W, R_TCS, R_BVY);
            7'd37: r = mk(OP_ADD, R_U, R_U, R_W);
            7'd38: r = mk(OP_MUL, R_W, R_OMC, R_LFY);
            7'd39: r = mk(OP_ADD, R_PY, R_U, R_W);
            // start velocity
            7'd40: r = mk(OP_MUL, R_U, R_SOT, R_BPX);
            7'd41: r = mk(OP_MUL, R_W, K_C, R_BVX);
            7'd42: r = mk(OP_ADD, R_U, R_U, R_W);
            7'd43: r = mk(OP_MUL, R_W, R_SOT, R_LFX);
            7'd44: r = mk(OP_SUB, R_VX, R_U, R_W);
            7'd45: r = mk(OP_MUL, R_U, R_SOT, R_BPY);
            7'd46: r = mk(OP_MUL, R_W, K_C, R_BVY);
            7'd47: r = mk(OP_ADD, R_U, R_U, R_W);
            7'd48: r = mk(OP_MUL, R_W, R_SOT, R_LFY);
            7'd49: r = mk(OP_SUB, R_VY, R_U, R_W);
            // weights
            7'd50: r = mk(OP_MUL, R_U, R_CM1, R_CM1);
            7'd51: r = mk(OP_MUL, R_U, K_A, R_U);
            7'd52: r = mk(OP_MUL, R_W, R_SOT, R_SOT);
            7'd53: r = mk(OP_MUL, R_W, K_B, R_W);
            7'd54: r = mk(OP_ADD, R_D, R_U, R_W);
            7'd55: r = mk(OP_MUL, R_KA, K_A, R_CM1);
            7'd56: r = mk(OP_MUL, R_KB, K_B, R_SOT);
            // modified foot x
            7'd57: r = mk(OP_MUL, R_U, K_C, R_PX);
            7'd58: r = mk(OP_SUB, R_T1, R_TX, R_U);
            7'd59: r = mk(OP_MUL, R_U, R_TCS, R_VX);
            7'd60: r = mk(OP_SUB, R_T1, R_T1, R_U);
            7'd61: r = mk(OP_MUL, R_U, R_SOT, R_PX);
            7'd62: r = mk(OP_SUB, R_T2, R_TVX, R_U);
            7'd63: r = mk(OP_MUL, R_U, K_C, R_VX);
            7'd64: r = mk(OP_SUB, R_T2, R_T2, R_U);
            7'd65: r = mk(OP_MUL, R_U, R_KA, R_T1);
            7'd66: r = mk(OP_DIV, R_U, R_U, R_D);
            7'd67: r = mk(OP_SUB, R_U, K_ZERO, R_U);
            7'd68: r = mk(OP_MUL, R_W, R_KB, R_T2);
            7'd69: r = mk(OP_DIV, R_W, R_W, R_D);
            7'd70: r = mk(OP_SUB, R_LFX, R_U, R_W);
            // modified foot y
            7'd71: r = mk(OP_MUL, R_U, K_C, R_PY);
            7'd72: r = mk(OP_SUB, R_T1, R_TY, R_U);
            7'd73: r = mk(OP_MUL, R_U, R_TCS, R_VY);
            7'd74: r = mk(OP_SUB, R_T1, R_T1, R_U);
            7'd75: r = mk(OP_MUL, R_U, R_SOT, R_PY);
            7'd76: r = mk(OP_SUB, R_T2, R_TVY, R_U);
            7'd77: r = mk(OP_MUL, R_U, K_C, R_VY);
            7'd78: r = mk(OP_SUB, R_T2, R_T2, R_U);
            7'd79: r = mk(OP_MUL, R_U, R_KA, R_T1);
            7'd80: r = mk(OP_DIV, R_U, R_U, R_D);
            7'd81: r = mk(OP_SUB, R_U, K_ZERO, R_U);
            7'd82: r = mk(OP_MUL, R_W, R_KB, R_T2);
            7'd83: r = mk(OP_DIV, R_W, R_W, R_D);
            7'd84: r = mk(OP_SUB, R_LFY, R_U, R_W);
            // commit the step state
            7'd85: r = mk(OP_ADD, R_FPX, R_LX, K_ZERO);
            7'd86: r = mk(OP_ADD, R_FPY, R_LY, K_ZERO);
            7'd87: r = mk(OP_ADD, R_BPX, R_PX, K_ZERO);
            7'd88: r = mk(OP_ADD, R_BPY, R_PY, K_ZERO);
            7'd89: r = mk(OP_ADD, R_BVX, R_VX, K_ZERO);
            7'd90: r = mk(OP_ADD, R_BVY, R_VY, K_ZERO);
            7'd91: r = mk(OP_ADD, R_PSX, K_SX, K_ZERO);
            7'd92: begin
                r = mk(OP_ADD, R_PSY, K_SY, K_ZERO);
                r.last = 1'b1;
            end
            default: begin
                r = mk(OP_ADD, R_W, K_ZERO, K_ZERO);
                r.last = 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/lipm_req_if.sv */
// ---------------------------------------------------------------------------
// lipm_req_if
// Step parameter request channel of the footstep planner.
// ---------------------------------------------------------------------------
interface lipm_req_if;
    logic               valid;
    logic               ready;
    logic               restart;
    logic signed [31:0] stride_x;
    logic signed [31:0] stride_y;

    modport source (output valid, output restart, output stride_x, output stride_y,
                    input ready);
    modport sink   (input valid, input restart, input stride_x, input stride_y,
                    output ready);
endinterface

/* rtl/core/lipm_rsp_if.sv */
// ---------------------------------------------------------------------------
// lipm_rsp_if
// Planned step result channel of the footstep planner.
// ---------------------------------------------------------------------------
interface lipm_rsp_if;
    logic               valid;
    logic               ready;
    logic [6:0]         step_index;
    logic signed [31:0] foot_x;
    logic signed [31:0] foot_y;
    logic signed [31:0] init_pos_x;
    logic signed [31:0] init_pos_y;
    logic signed [31:0] init_vel_x;
    logic signed [31:0] init_vel_y;
    logic [1:0]         status;

    modport source (output valid, output step_index, output foot_x, output foot_y,
                    output init_pos_x, output init_pos_y, output init_vel_x,
                    output init_vel_y, output status, input ready);
    modport sink   (input valid, input step_index, input foot_x, input foot_y,
                    input init_pos_x, input init_pos_y, input init_vel_x,
                    input init_vel_y, input status, output ready);
endinterface

/* rtl/core/lipm_footstep_planner_unit.sv */
// ---------------------------------------------------------------------------
// lipm_footstep_planner_unit
// Linear inverted pendulum foot placement planner: one step parameter in,
// the start state and modified foot placement of the previous step out.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake       contents
//  i_req     in         valid / ready   restart, stride_x, stride_y
//  o_rsp     out        valid / ready   step_index, foot, init pos, init vel, status
//  i_cfg_*   in         write enable    register index, 32-bit write data
//
//  A small sequencer runs a micro-program through one shared add/sub,
//  32x32 multiply and 48-step restoring divide unit over a scratch memory.
//  Each operation runs read, execute and write-back; a divide by nonzero adds
//  the divide state. An item beyond the step limit goes straight to done.
//  i_req.ready is high only while idle; the finished result sits in the output
//  register, and a stalled o_rsp holds the next result in the sequencer.
//  Reset is synchronous, active low, and resets control and config state only.
// ---------------------------------------------------------------------------
module lipm_footstep_planner_unit
    import lipm_fp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    lipm_req_if.sink          i_req,
    lipm_rsp_if.source        o_rsp
);

    // configuration registers
    logic [30:0]        r_cosh, r_sinh, r_tc, r_wpos, r_wvel;
    logic signed [31:0] r_spx, r_spy;

    // sequencer
    t_state             r_state, n_state;
    logic [PC_W-1:0]    r_pc;
    t_instr             ins;
    logic [STEP_W-1:0]  r_step, r_n;
    logic               r_limit;
    logic               r_sat;
    logic signed [31:0] r_sx, r_sy;

    // shared unit
    logic signed [31:0] r_opa, r_opb;
    logic signed [31:0] r_res;
    logic               r_ovf;
    logic signed [63:0] r_prod;
    logic [31:0]        r_rem;
    logic [31:0]        r_dvs;
    logic [DIV_BITS-1:0] r_dvd;
    logic [DIV_CW-1:0]  r_cnt;
    logic               r_qneg;
    logic               r_dz;
    t_satv              wb;
    logic [31:0]        rem_sh;
    logic [32:0]        trial;
    logic [STEP_W-1:0]  req_n;

    // scratch memory
    logic signed [31:0] r_mem [2**SLOT_W];

    // staged result fields
    logic signed [31:0] r_fx, r_fy, r_px, r_py, r_vx, r_vy;

    // output register
    logic               r_ovalid;
    logic [STEP_W-1:0]  r_o_idx;
    logic signed [31:0] r_o_fx, r_o_fy, r_o_px, r_o_py, r_o_vx, r_o_vy;
    logic [1:0]         r_o_stat;

    logic acc_in, out_free;

    assign ins      = prog_rom(r_pc);
    assign acc_in   = i_req.valid && i_req.ready;
    assign out_free = !r_ovalid || o_rsp.ready;
    assign req_n    = i_req.restart ? '0 : r_step;

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.step_index = r_o_idx;
    assign o_rsp.foot_x     = r_o_fx;
    assign o_rsp.foot_y     = r_o_fy;
    assign o_rsp.init_pos_x = r_o_px;
    assign o_rsp.init_pos_y = r_o_py;
    assign o_rsp.init_vel_x = r_o_vx;
    assign o_rsp.init_vel_y = r_o_vy;
    assign o_rsp.status     = r_o_stat;

    // special operand sources
    function automatic logic signed [31:0] special_val(input logic [SRC_W-1:0] code);
        logic signed [31:0] v;
        case (code)
            K_ZERO:  v = '0;
            K_ONE:   v = Q_ONE;
            K_HALF:  v = Q_HALF;
            K_NHALF: v = Q_NHALF;
            K_SGNH:  v = r_n[0] ? Q_NHALF : Q_HALF;
            K_FOOTY: v = FIRST_FOOT_Y;
            K_C:     v = {1'b0, r_cosh};
            K_S:     v = {1'b0, r_sinh};
            K_TC:    v = {1'b0, r_tc};
            K_A:     v = {1'b0, r_wpos};
            K_B:     v = {1'b0, r_wvel};
            K_SPX:   v = r_spx;
            K_SPY:   v = r_spy;
            K_SX:    v = r_sx;
            K_SY:    v = r_sy;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cosh <= 31'd473842;
            r_sinh <= 31'd469352;
            r_tc   <= 31'd19661;
            r_wpos <= 31'd655360;
            r_wvel <= 31'd65536;
            r_spx  <= '0;
            r_spy  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COSH:    r_cosh <= i_cfg_data[30:0];
                CFG_SINH:    r_sinh <= i_cfg_data[30:0];
                CFG_TC:      r_tc   <= i_cfg_data[30:0];
                CFG_WPOS:    r_wpos <= i_cfg_data[30:0];
                CFG_WVEL:    r_wvel <= i_cfg_data[30:0];
                CFG_START_X: r_spx  <= i_cfg_data;
                CFG_START_Y: r_spy  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // divider step and write-back value
    always_comb begin
        rem_sh = {r_rem[30:0], r_dvd[DIV_BITS-1]};
        trial  = {1'b0, rem_sh} - {1'b0, r_dvs};
        case (ins.op)
            OP_MUL:  wb = sat64(r_prod >>> 16);
            OP_DIV:  wb = r_dz ? t_satv'{1'b1, r_res}
                               : sat64(r_qneg ? -$signed({16'b0, r_dvd})
                                              : $signed({16'b0, r_dvd}));
            default: wb = '{r_ovf, r_res};
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    n_state = (req_n > STEP_W'(MAX_STEPS)) ? S_DONE : S_READ;
                end
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                if (ins.op == OP_DIV && r_opb != '0) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_WB;
                end
            end
            S_DIV: begin
                if (r_cnt == DIV_CW'(DIV_BITS - 1)) begin
                    n_state = S_WB;
                end
            end
            S_WB:   n_state = ins.last ? S_DONE : S_READ;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= '0;
            r_step  <= '0;
            r_n     <= '0;
            r_limit <= 1'b0;
            r_sat   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        r_n     <= req_n;
                        r_limit <= (req_n > STEP_W'(MAX_STEPS));
                        r_pc    <= '0;
                        r_sat   <= 1'b0;
                    end
                end
                S_WB: begin
                    r_sat <= r_sat | wb.ovf;
                    if (ins.branch) begin
                        r_pc <= (r_n == '0) ? STEP0_PC : STEPN_PC;
                    end else begin
                        r_pc <= r_pc + PC_W'(1);
                    end
                end
                S_DONE: begin
                    if (out_free && !r_limit) begin
                        r_step <= r_n + STEP_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // shared arithmetic unit and scratch memory
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    r_sx <= i_req.stride_x;
                    r_sy <= i_req.stride_y;
                end
            end
            S_READ: begin
                r_opa <= ins.a[SRC_W-1] ? special_val(ins.a) : r_mem[ins.a[SLOT_W-1:0]];
                r_opb <= ins.b[SRC_W-1] ? special_val(ins.b) : r_mem[ins.b[SLOT_W-1:0]];
            end
            S_EXEC: begin
                case (ins.op)
                    OP_ADD: {r_ovf, r_res} <= sat64(64'(r_opa) + 64'(r_opb));
                    OP_SUB: {r_ovf, r_res} <= sat64(64'(r_opa) - 64'(r_opb));
                    OP_PM: begin
                        if (r_n[0]) begin
                            {r_ovf, r_res} <= sat64(64'(r_opa) + 64'(r_opb));
                        end else begin
                            {r_ovf, r_res} <= sat64(64'(r_opa) - 64'(r_opb));
                        end
                    end
                    OP_MUL: r_prod <= 64'(r_opa) * 64'(r_opb);
                    OP_DIV: begin
                        r_dz   <= (r_opb == '0);
                        r_res  <= (r_opa == '0) ? '0 : (r_opa[31] ? S32_MIN : S32_MAX);
                        r_rem  <= '0;
                        r_dvs  <= mag32(r_opb);
                        r_dvd  <= {mag32(r_opa), 16'b0};
                        r_qneg <= r_opa[31] ^ r_opb[31];
                        r_cnt  <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_DIV: begin
                // one quotient bit a cycle
                if (!trial[32]) begin
                    r_rem <= trial[31:0];
                end else begin
                    r_rem <= rem_sh;
                end
                r_dvd <= {r_dvd[DIV_BITS-2:0], !trial[32]};
                r_cnt <= r_cnt + DIV_CW'(1);
            end
            S_WB: begin
                r_mem[ins.dst[SLOT_W-1:0]] <= wb.val;
                if (ins.dst == R_LFX) r_fx <= wb.val;
                if (ins.dst == R_LFY) r_fy <= wb.val;
                if (ins.dst == R_BPX) r_px <= wb.val;
                if (ins.dst == R_BPY) r_py <= wb.val;
                if (ins.dst == R_BVX) r_vx <= wb.val;
                if (ins.dst == R_BVY) r_vy <= wb.val;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            if (r_limit) begin
                r_o_idx  <= '0;
                r_o_fx   <= '0;
                r_o_fy   <= '0;
                r_o_px   <= '0;
                r_o_py   <= '0;
                r_o_vx   <= '0;
                r_o_vy   <= '0;
                r_o_stat <= STAT_LIMIT;
            end else begin
                r_o_idx  <= r_n;
                r_o_fx   <= r_fx;
                r_o_fy   <= r_fy;
                r_o_px   <= r_px;
                r_o_py   <= r_py;
                r_o_vx   <= r_vx;
                r_o_vy   <= r_vy;
                r_o_stat <= r_sat ? STAT_SAT : STAT_OK;
            end
        end
    end

endmodule
